// ----- hw/rtl/lbvs_pkg.sv -----
// Shared types, constants and helpers for the linear blend skinning core.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package lbvs_pkg;

    localparam int MAX_BONES_DEF = 256;
    localparam int NUM_INF       = 4;
    localparam int ROW_WORDS     = 12;
    localparam logic [31:0] Q16_ONE = 32'h0001_0000;

    localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

    // Action codes carried in tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SKIN  = 1'b1;

    typedef logic [31:0] word_t;
    // Used part of a bone matrix: rows 0..3, columns 0..2, index row*3+col
    typedef word_t [ROW_WORDS-1:0] mrow_t;

    typedef struct packed {
        logic [31:0] ids;
        logic [63:0] weights;
        word_t [2:0] pos;
        word_t [2:0] norm;
        logic        last;
    } vtx_t;

    typedef struct packed {
        word_t [2:0] pos;
        word_t [2:0] norm;
        logic        last;
    } vec_t;

    function automatic mrow_t identity_row();
        mrow_t r;
        for (int k = 0; k < ROW_WORDS; k++) begin
            r[k] = (k == 0 || k == 4 || k == 8) ? Q16_ONE : 32'h0;
        end
        return r;
    endfunction

    function automatic word_t sat32(input logic signed [66:0] x);
        word_t r;
        if (x > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/linear_blend_vertex_skinning_core.sv -----
// Four-bone linear blend skinning core: six register stages (input, store read,
// weight products, blend sum, transform products, rounded output).
// Throughput: one transaction per cycle unless m_tready back-pressure stalls; writes give no result.
// Reset clears all bone valid flags at once so every bone reads as identity.
`default_nettype none
module linear_blend_vertex_skinning_core #(
    parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // matrix_address, element_value, bone_ids, bone_weights,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, zero pad
    input  wire logic [335:0] s_tdata,
    input  wire logic         s_tuser,   // action
    input  wire logic         s_tlast,   // last_vertex
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
    output logic [191:0]      m_tdata,
    output logic              m_tlast    // mesh_done
);
    import lbvs_pkg::*;

    logic         v0_reg;
    logic         act0_reg;
    logic [11:0]  addr0_reg;
    word_t        val0_reg;
    vtx_t         vtx0_reg;
    logic         st_in_ready, st_out_valid;
    vtx_t         st_vtx;
    mrow_t [3:0]  st_rows;
    logic         bl_in_ready, bl_out_valid;
    vec_t         bl_vec;
    mrow_t        bl_mat;
    logic         xf_in_ready;
    vec_t         xf_vec;

    // a write in the input stage never waits on the bone store
    assign s_tready = !v0_reg || (act0_reg == ACT_WRITE) || st_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_tready) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act0_reg         <= s_tuser;
            addr0_reg        <= s_tdata[11:0];
            val0_reg         <= s_tdata[43:12];
            vtx0_reg.ids     <= s_tdata[75:44];
            vtx0_reg.weights <= s_tdata[139:76];
            vtx0_reg.pos     <= s_tdata[235:140];
            vtx0_reg.norm    <= s_tdata[331:236];
            vtx0_reg.last    <= s_tlast;
        end
    end

    lbvs_bone_store #(
        .MAX_BONES (MAX_BONES)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (v0_reg && (act0_reg == ACT_WRITE)),
        .wr_addr   (addr0_reg),
        .wr_data   (val0_reg),
        .in_valid  (v0_reg && (act0_reg == ACT_SKIN)),
        .in_ready  (st_in_ready),
        .in_vtx    (vtx0_reg),
        .out_valid (st_out_valid),
        .out_ready (bl_in_ready),
        .out_vtx   (st_vtx),
        .out_rows  (st_rows)
    );

    lbvs_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_out_valid),
        .in_ready  (bl_in_ready),
        .in_vtx    (st_vtx),
        .in_rows   (st_rows),
        .out_valid (bl_out_valid),
        .out_ready (xf_in_ready),
        .out_vec   (bl_vec),
        .out_mat   (bl_mat)
    );

    lbvs_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bl_out_valid),
        .in_ready  (xf_in_ready),
        .in_vec    (bl_vec),
        .in_mat    (bl_mat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vec   (xf_vec)
    );

    assign m_tdata = {xf_vec.norm, xf_vec.pos};
    assign m_tlast = xf_vec.last;

endmodule
`default_nettype wire

// ----- hw/rtl/lbvs_bone_store.sv -----
// Bone matrix store: four read copies, one shared write port, per-bone valid flags.
// Depends on lbvs_pkg.
`default_nettype none
module lbvs_bone_store #(
    parameter int MAX_BONES = lbvs_pkg::MAX_BONES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_en,
    input  wire logic [11:0]         wr_addr,
    input  wire lbvs_pkg::word_t     wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lbvs_pkg::vtx_t      in_vtx,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lbvs_pkg::vtx_t           out_vtx,
    output lbvs_pkg::mrow_t [3:0]    out_rows
);
    import lbvs_pkg::*;

    localparam int BONE_W = $clog2(MAX_BONES);

    logic [MAX_BONES-1:0] valid_reg;
    logic                 v_reg;
    vtx_t                 vtx_reg;
    logic                 load;
    logic                 wr_ok;
    logic [BONE_W-1:0]    wr_idx;
    logic [3:0]           wr_k;
    mrow_t                wr_row;

    assign wr_idx = wr_addr[BONE_W+3:4];
    assign wr_k   = {2'b00, wr_addr[3:2]} * 4'd3 + {2'b00, wr_addr[1:0]};
    // drop writes to bones beyond the store and to the unused fourth column
    assign wr_ok  = wr_en && (int'(wr_addr[11:4]) < MAX_BONES) && (wr_addr[1:0] != 2'd3);

    always_comb begin
        wr_row       = identity_row();
        wr_row[wr_k] = wr_data;
    end

    assign in_ready = !v_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            v_reg     <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (in_ready) begin
                v_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vtx_reg <= in_vtx;
        end
    end

    for (genvar g = 0; g < NUM_INF; g++) begin : g_copy
        mrow_t             mem [MAX_BONES];
        mrow_t             rdata_reg;
        logic              use_reg;
        logic [7:0]        id;
        logic [BONE_W-1:0] idx;
        logic              hit;

        assign id  = in_vtx.ids[8*g +: 8];
        assign idx = id[BONE_W-1:0];
        assign hit = (int'(id) < MAX_BONES) && valid_reg[idx];

        // first write to an untouched bone fills the rest of its row with identity
        always_ff @(posedge aclk) begin
            if (wr_ok) begin
                if (valid_reg[wr_idx]) begin
                    mem[wr_idx][wr_k] <= wr_data;
                end else begin
                    mem[wr_idx] <= wr_row;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (load) begin
                rdata_reg <= mem[idx];
                use_reg   <= hit;
            end
        end

        assign out_rows[g] = use_reg ? rdata_reg : identity_row();
    end

    assign out_valid = v_reg;
    assign out_vtx   = vtx_reg;

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && in_valid)) else $error("store write and read in one cycle");

    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("bone valid flag cleared");

    a_write_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ok |=> valid_reg[$past(wr_idx)]) else $error("written bone not marked valid");

endmodule
`default_nettype wire

// ----- hw/rtl/lbvs_blend.sv -----
// Weight blend: per-bone weight products, then sum, round and saturate,
// or bone 0's raw row when bone 1's id is zero. Depends on lbvs_pkg.
`default_nettype none
module lbvs_blend (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lbvs_pkg::vtx_t       in_vtx,
    input  wire lbvs_pkg::mrow_t [3:0] in_rows,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lbvs_pkg::vec_t            out_vec,
    output lbvs_pkg::mrow_t           out_mat
);
    import lbvs_pkg::*;

    logic               va_reg, vb_reg;
    logic               rdy_b;
    logic signed [48:0] prod_next [NUM_INF][ROW_WORDS];
    logic signed [48:0] prod_reg  [NUM_INF][ROW_WORDS];
    mrow_t              raw0_reg;
    logic               id1z_reg;
    vec_t               veca_reg, vecb_reg;
    mrow_t              mat_next, mat_reg;
    logic               use2, use3;

    assign rdy_b    = !vb_reg || out_ready;
    assign in_ready = !va_reg || rdy_b;

    assign use2 = in_vtx.ids[23:16] != 8'd0;
    assign use3 = use2 && (in_vtx.ids[31:24] != 8'd0);

    always_comb begin
        for (int g = 0; g < NUM_INF; g++) begin
            for (int k = 0; k < ROW_WORDS; k++) begin
                prod_next[g][k] = $signed({1'b0, in_vtx.weights[16*g +: 16]})
                                * $signed(in_rows[g][k]);
                if ((g == 2 && !use2) || (g == 3 && !use3)) begin
                    prod_next[g][k] = '0;
                end
            end
        end
    end

    always_comb begin
        logic signed [50:0] acc;
        logic signed [50:0] rnd;
        for (int k = 0; k < ROW_WORDS; k++) begin
            acc = 51'(prod_reg[0][k]) + 51'(prod_reg[1][k])
                + 51'(prod_reg[2][k]) + 51'(prod_reg[3][k]);
            rnd = (acc + 51'sd16384) >>> 15;
            mat_next[k] = id1z_reg ? raw0_reg[k] : sat32(67'(rnd));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg      <= prod_next;
            raw0_reg      <= in_rows[0];
            id1z_reg      <= in_vtx.ids[15:8] == 8'd0;
            veca_reg.pos  <= in_vtx.pos;
            veca_reg.norm <= in_vtx.norm;
            veca_reg.last <= in_vtx.last;
        end
        if (va_reg && rdy_b) begin
            mat_reg  <= mat_next;
            vecb_reg <= veca_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_vec   = vecb_reg;
    assign out_mat   = mat_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/lbvs_xform.sv -----
// Point transform of position and normal by the blended matrix, with rounding.
// Depends on lbvs_pkg.
`default_nettype none
module lbvs_xform (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lbvs_pkg::vec_t  in_vec,
    input  wire lbvs_pkg::mrow_t in_mat,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lbvs_pkg::vec_t       out_vec
);
    import lbvs_pkg::*;

    logic               va_reg, vb_reg;
    logic               rdy_b;
    logic signed [63:0] pp_reg [3][3];
    logic signed [63:0] np_reg [3][3];
    word_t [2:0]        t_reg;
    logic               last_reg;
    vec_t               res_next, res_reg;

    assign rdy_b    = !vb_reg || out_ready;
    assign in_ready = !va_reg || rdy_b;

    always_comb begin
        logic signed [66:0] sp, sn;
        for (int j = 0; j < 3; j++) begin
            sp = (67'($signed(t_reg[j])) <<< 16) + 67'(pp_reg[j][0])
               + 67'(pp_reg[j][1]) + 67'(pp_reg[j][2]) + 67'sd32768;
            sn = (67'($signed(t_reg[j])) <<< 16) + 67'(np_reg[j][0])
               + 67'(np_reg[j][1]) + 67'(np_reg[j][2]) + 67'sd32768;
            res_next.pos[j]  = sat32(sp >>> 16);
            res_next.norm[j] = sat32(sn >>> 16);
        end
        res_next.last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    pp_reg[j][i] <= $signed(in_vec.pos[i])  * $signed(in_mat[i*3 + j]);
                    np_reg[j][i] <= $signed(in_vec.norm[i]) * $signed(in_mat[i*3 + j]);
                end
                t_reg[j] <= in_mat[9 + j];
            end
            last_reg <= in_vec.last;
        end
        if (va_reg && rdy_b) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_vec   = res_reg;

endmodule
`default_nettype wire
